>>> rtl/core/gn2_pkg.sv
// ----------------------------------------------------------------------------
// gn2_pkg: shared constants for the 2D gradient noise core
// Table geometry, fixed-point format and sequencer codes.
// ----------------------------------------------------------------------------
package gn2_pkg;
   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = 8;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_W      = 19;

   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
endpackage

>>> rtl/core/gn2_ram.sv
// ----------------------------------------------------------------------------
// gn2_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module gn2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

>>> rtl/core/gradient_noise_2d_eval_core.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_eval_core: improved gradient noise at a 2D point
// Permutation table in a single-port RAM; one shared multiplier under a
// sequencer computes fades and lerps.
// ----------------------------------------------------------------------------
// Sequence: an evaluate request runs the fade steps, the table reads, the lerps and
//   the output step in that order; a write request is taken in S_IDLE. A new evaluate
//   request is accepted only once the last one has left S_OUT; writes go back to back,
//   also while a result waits in rsp_tdata. The ten chained table reads on one RAM port
//   and the single 18x21 multiplier set the pace. Reset: synchronous; a clearing pass
//   over all 256 entries loads the identity table, during which req_tready is low.
module gradient_noise_2d_eval_core
   import gn2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // x_coord[31:0], y_coord[63:32],
                                   // entry_index[71:64], entry_value[79:72]
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // noise_value[18:0], zero fill
);
   localparam logic [4:0] S_INIT = 5'd0,  S_IDLE = 5'd1,  S_FADE = 5'd2,
                          S_RD   = 5'd3,  S_GRAD = 5'd4,  S_LERP = 5'd5,
                          S_OUT  = 5'd6;

   logic [4:0]  state_ff, state_in;
   logic [8:0]  cnt_ff, cnt_in;       // init sweep / micro step
   logic [7:0]  cx_ff, cy_ff, hx0_ff, hx1_ff;
   logic [16:0] fx_ff, fy_ff;
   logic signed [39:0] acc_ff [8];    // scratch: p,t2,t3,u / p,t2,t3,v, lerps
   logic signed [18:0] g_ff [4];
   logic signed [39:0] r_ff;
   logic        rv_ff;
   logic [18:0] out_ff;

   // shared multiplier operands
   logic signed [17:0] ma;
   logic signed [20:0] mb;
   logic signed [38:0] prod;
   logic signed [63:0] pfl;
   assign prod = ma * mb;
   assign pfl  = 64'(prod >>> FRAC_BITS);

   // RAM
   logic       ram_we;
   logic [7:0] ram_addr, ram_wd, ram_rd;
   gn2_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
   );

   function automatic logic signed [18:0] grad(input logic [3:0] h,
                                                input logic signed [17:0] dx,
                                                input logic signed [17:0] dy);
      logic signed [18:0] a, b;
      a = (h < 4'd8) ? 19'(dx) : 19'(dy);
      if (h < 4'd4) b = 19'(dy);
      else if (h == 4'd12 || h == 4'd14) b = 19'(dx);
      else b = '0;
      if (h[0]) a = -a;
      if (h[1]) b = -b;
      return a + b;
   endfunction

   logic signed [17:0] dx0, dx1, dy0, dy1;
   assign dx0 = 18'($signed({1'b0, fx_ff}));
   assign dy0 = 18'($signed({1'b0, fy_ff}));
   assign dx1 = dx0 - 18'sd65536;
   assign dy1 = dy0 - 18'sd65536;

   // micro step of fade: cnt[3]=axis, cnt[2:0]=step
   logic [16:0] tcur;
   assign tcur = cnt_ff[3] ? fy_ff : fx_ff;

   always_comb begin
      ma = '0; mb = '0;
      unique case (state_ff)
         S_FADE: begin
            unique case (cnt_ff[2:0])
               3'd0: begin ma = 18'(tcur); mb = 21'sd983040 - 21'(tcur) * 21'sd6; end
               3'd1: begin ma = 18'(tcur); mb = 21'(tcur); end
               3'd2: begin ma = 18'(acc_ff[{cnt_ff[3], 2'd1}]); mb = 21'(tcur); end
               default: begin ma = 18'(acc_ff[{cnt_ff[3], 2'd2}]);
                              mb = 21'(acc_ff[{cnt_ff[3], 2'd0}]); end
            endcase
         end
         S_LERP: begin
            unique case (cnt_ff[1:0])
               2'd0: begin ma = 18'(acc_ff[3]); mb = 21'(g_ff[1]) - 21'(g_ff[0]); end
               2'd1: begin ma = 18'(acc_ff[3]); mb = 21'(g_ff[3]) - 21'(g_ff[2]); end
               default: begin ma = 18'(acc_ff[7]); mb = 21'(acc_ff[2] - acc_ff[1]); end
            endcase
         end
         default: ;
      endcase
   end

   logic req_ok;
   logic out_free;
   assign req_tready = (state_ff == S_IDLE);
   assign req_ok = req_tvalid && req_tready;
   assign out_free = !rv_ff || rsp_tready;

   // RAM address: chained reads, data in the cycle after its address
   always_comb begin
      ram_we = 1'b0; ram_addr = cnt_ff[7:0]; ram_wd = cnt_ff[7:0];
      unique case (state_ff)
         S_INIT: ram_we = 1'b1;
         S_IDLE: begin
            ram_we = req_ok && req_tuser == OP_WRITE;
            ram_addr = req_tdata[71:64];
            ram_wd = req_tdata[79:72];
         end
         S_RD: begin
            unique case (cnt_ff[3:0])
               4'd0: ram_addr = cx_ff;
               4'd1: ram_addr = cx_ff + 8'd1;
               4'd2: ram_addr = hx0_ff + cy_ff;
               4'd4: ram_addr = hx0_ff + cy_ff + 8'd1;
               4'd6: ram_addr = hx1_ff + cy_ff;
               4'd8: ram_addr = hx1_ff + cy_ff + 8'd1;
               default: ram_addr = ram_rd;                // second hop of a corner hash
            endcase
         end
         default: ;
      endcase
   end

   logic signed [39:0] rs;
   always_comb begin
      rs = r_ff;
      if (rs < -40'sd262144) rs = -40'sd262144;
      if (rs > 40'sd262143) rs = 40'sd262143;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + 9'd1;
      unique case (state_ff)
         S_INIT: if (cnt_ff == 9'd255) state_in = S_IDLE;
         S_IDLE: begin
            cnt_in = '0;
            if (req_ok && req_tuser == OP_EVAL) state_in = S_FADE;
         end
         S_FADE: if (cnt_ff[2:0] == 3'd3) begin
            cnt_in = {5'd0, 4'b1000};
            if (cnt_ff[3]) begin state_in = S_RD; cnt_in = '0; end
         end
         S_RD: if (cnt_ff[3:0] == 4'd10) begin state_in = S_LERP; cnt_in = '0; end
         S_LERP: if (cnt_ff[1:0] == 2'd2) state_in = S_OUT;
         S_OUT: begin
            cnt_in = '0;
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == S_OUT && out_free) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ok) begin
         cx_ff <= req_tdata[23:16];
         cy_ff <= req_tdata[55:48];
         fx_ff <= {1'b0, req_tdata[15:0]};
         fy_ff <= {1'b0, req_tdata[47:32]};
      end
      if (state_ff == S_FADE) begin
         unique case (cnt_ff[2:0])
            3'd0: acc_ff[{cnt_ff[3], 2'd0}] <= 40'sd655360 - 40'(pfl);
            3'd1: acc_ff[{cnt_ff[3], 2'd1}] <= 40'(pfl);
            3'd2: acc_ff[{cnt_ff[3], 2'd2}] <= 40'(pfl);
            default: acc_ff[{cnt_ff[3], 2'd3}] <= 40'(pfl);
         endcase
      end
      if (state_ff == S_RD) begin
         unique case (cnt_ff[3:0])
            4'd1: hx0_ff <= ram_rd;
            4'd2: hx1_ff <= ram_rd;
            4'd4: g_ff[0] <= grad(ram_rd[3:0], dx0, dy0);
            4'd6: g_ff[2] <= grad(ram_rd[3:0], dx0, dy1);
            4'd8: g_ff[1] <= grad(ram_rd[3:0], dx1, dy0);
            4'd10: g_ff[3] <= grad(ram_rd[3:0], dx1, dy1);
            default: ;
         endcase
      end
      if (state_ff == S_LERP) begin
         unique case (cnt_ff[1:0])
            2'd0: acc_ff[1] <= 40'(g_ff[0]) + 40'(pfl);
            2'd1: acc_ff[2] <= 40'(g_ff[2]) + 40'(pfl);
            default: r_ff <= acc_ff[1] + 40'(pfl);
         endcase
      end
      if (state_ff == S_OUT && out_free) out_ff <= rs[18:0];
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {5'd0, out_ff};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_OUT) else $error("stray result");
   a_init_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !rsp_tvalid) else $error("result during init");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while waiting");
endmodule
